// File: rtl/lruwb_pkg.sv
// Shared types, constants and widths for the LRU write-back cache.
package lruwb_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_CACHE_ENTRIES = 8;
  localparam int DEF_MEM_WORDS     = 1024;

  // Fixed field widths of the request and result channels.
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 16;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CAP_W      = 4;
  localparam int MSIZE_W    = 11;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE = 2'd1;

  // Register reset values.
  localparam logic [CAP_W-1:0]   CAP_RESET   = 4'd8;
  localparam logic [MSIZE_W-1:0] MSIZE_RESET = 11'd1024;

  // Command codes.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Summary of a tag lookup, as seen by the controller.
  typedef struct packed {
    logic hit;    // address is held in a valid entry
    logic room;   // occupancy is below the effective capacity
    logic empty;  // no entry is occupied
  } lookup_t;

  // Update applied to the tag and rank state when a request completes.
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_HIT,
    UPD_ALLOC,
    UPD_EVICT
  } upd_kind_e;

endpackage

// File: rtl/lruwb_backing_mem.sv
// Backing word memory with a clearing pass after reset.
module lruwb_backing_mem #(
  parameter int WORDS = lruwb_pkg::DEF_MEM_WORDS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        busy_o,
  input  logic                        rd_en_i,
  input  logic [$clog2(WORDS)-1:0]    rd_addr_i,
  output logic [lruwb_pkg::DATA_W-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [$clog2(WORDS)-1:0]    wr_addr_i,
  input  logic [lruwb_pkg::DATA_W-1:0] wr_data_i
);
  import lruwb_pkg::*;

  localparam int AW = $clog2(WORDS);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  logic [DATA_W-1:0] mem [WORDS];
  logic              clear_q, clear_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;

  // The clearing pass walks every word once, then hands the port to the user.
  always_comb begin
    clear_d = clear_q;
    cnt_d   = cnt_q;
    if (clear_q) begin
      cnt_d = cnt_q + AW'(1);
      if (cnt_q == LAST_WORD) begin
        clear_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q <= 1'b1;
      cnt_q   <= '0;
    end else begin
      clear_q <= clear_d;
      cnt_q   <= cnt_d;
    end
  end

  // Write port is owned by the clearing pass while it runs.
  assign we    = clear_q | wr_en_i;
  assign waddr = clear_q ? cnt_q : wr_addr_i;
  assign wdata = clear_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

  assign busy_o = clear_q;

endmodule

// File: rtl/lruwb_data_mem.sv
// Cache entry data memory, one write and one registered read port.
module lruwb_data_mem #(
  parameter int DEPTH = lruwb_pkg::DEF_CACHE_ENTRIES
) (
  input  logic                                       clk_i,
  input  logic                                       rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [lruwb_pkg::DATA_W-1:0]               rd_data_o,
  input  logic                                       wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [lruwb_pkg::DATA_W-1:0]               wr_data_i
);
  import lruwb_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: rtl/lruwb_tag_array.sv
// Entry tags, recency ranks and occupancy, with parallel lookup and LRU update.
module lruwb_tag_array #(
  parameter int NUM_ENTRIES = lruwb_pkg::DEF_CACHE_ENTRIES,
  parameter int AW          = $clog2(lruwb_pkg::DEF_MEM_WORDS)
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic [lruwb_pkg::CAP_W-1:0]                            cap_i,
  input  logic [AW-1:0]                                          lookup_addr_i,
  output lruwb_pkg::lookup_t                                     lookup_o,
  output logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0] hit_slot_o,
  output logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0] victim_slot_o,
  output logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0] alloc_slot_o,
  output logic [AW-1:0]                                          victim_tag_o,
  input  lruwb_pkg::upd_kind_e                                   upd_i,
  input  logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0] upd_slot_i,
  input  logic [AW-1:0]                                          upd_tag_i
);
  import lruwb_pkg::*;

  localparam int SW   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW   = $clog2(NUM_ENTRIES + 1);
  localparam int CMPW = ((CW > CAP_W) ? CW : CAP_W) + 1;

  logic [AW-1:0]   tag_q  [NUM_ENTRIES];
  logic [SW-1:0]   rank_q [NUM_ENTRIES];
  logic [SW-1:0]   rank_d [NUM_ENTRIES];
  logic [CW-1:0]   occ_q, occ_d;
  logic [NUM_ENTRIES-1:0] valid;
  logic [SW-1:0]   last_rank;
  logic [SW-1:0]   limit;
  logic [CMPW-1:0] cap_eff;
  logic            hit;

  assign last_rank = SW'(occ_q - CW'(1));

  // Effective capacity: register value clamped to the number of entries.
  always_comb begin
    if (CMPW'(cap_i) > CMPW'(NUM_ENTRIES)) begin
      cap_eff = CMPW'(NUM_ENTRIES);
    end else begin
      cap_eff = CMPW'(cap_i);
    end
  end

  // Parallel tag and rank compare; the lowest matching slot wins.
  always_comb begin
    hit           = 1'b0;
    hit_slot_o    = '0;
    victim_slot_o = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      valid[i] = CW'(i) < occ_q;
      if (valid[i] && tag_q[i] == lookup_addr_i) begin
        hit        = 1'b1;
        hit_slot_o = SW'(i);
      end
      if (valid[i] && rank_q[i] == last_rank) begin
        victim_slot_o = SW'(i);
      end
    end
  end

  assign victim_tag_o   = tag_q[victim_slot_o];
  assign alloc_slot_o   = occ_q[SW-1:0];
  assign lookup_o.hit   = hit;
  assign lookup_o.room  = CMPW'(occ_q) < cap_eff;
  assign lookup_o.empty = occ_q == '0;

  // Recency update: entries more recent than the touched one age by a step.
  always_comb begin
    occ_d = occ_q;
    case (upd_i)
      UPD_HIT:   limit = rank_q[upd_slot_i];
      UPD_EVICT: limit = last_rank;
      default:   limit = '0;
    endcase
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (upd_i != UPD_NONE && valid[i] &&
          (upd_i == UPD_ALLOC || rank_q[i] < limit)) begin
        rank_d[i] = rank_q[i] + SW'(1);
      end
    end
    if (upd_i != UPD_NONE) begin
      rank_d[upd_slot_i] = '0;
    end
    if (upd_i == UPD_ALLOC) begin
      occ_d = occ_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      occ_q <= occ_d;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // A new address is recorded on allocation or replacement.
  always_ff @(posedge clk_i) begin
    if (upd_i == UPD_ALLOC || upd_i == UPD_EVICT) begin
      tag_q[upd_slot_i] <= upd_tag_i;
    end
  end

endmodule

// File: rtl/lru_write_back_cache_unit.sv
// Top level of the fully associative LRU write-back cache with its backing memory.
//
// Usage:
//   Requests arrive on the in_* channel (command, address, write_data) with a
//   valid/ready handshake; each request yields exactly one result on the out_*
//   channel (read_data, hit, status), in order.
//   The cfg_* channel writes cache_capacity (index 0) and memory_size (index 1);
//   it is always ready and should be used only while no request is in flight.
//   At the accept edge a request reads the tag flops, the entry data memory and
//   the backing memory; the completion edge writes back and updates the
//   recency ranks. The memories have a registered read port, so a new request
//   is taken only after the current one has completed, and its result is
//   registered at the completion edge.
//   The result sits in an output register. A request may be accepted while a
//   result waits; if the receiver still stalls, completion of that request
//   waits until the output register is free.
//   After reset the backing memory is cleared one word per cycle, and no
//   request is accepted until that pass ends.
module lru_write_back_cache_unit #(
  parameter int CACHE_ENTRIES = lruwb_pkg::DEF_CACHE_ENTRIES,
  parameter int MEM_WORDS     = lruwb_pkg::DEF_MEM_WORDS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   command_i,
  input  logic [lruwb_pkg::ADDR_W-1:0]           address_i,
  input  logic signed [lruwb_pkg::DATA_W-1:0]    write_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [lruwb_pkg::DATA_W-1:0]    read_data_o,
  output logic                                   hit_o,
  output logic                                   status_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [lruwb_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [lruwb_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import lruwb_pkg::*;

  localparam int AW   = $clog2(MEM_WORDS);
  localparam int SW   = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int EXTW = ADDR_W + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic              state_q, state_d;
  logic [CAP_W-1:0]  cap_q;
  logic [MSIZE_W-1:0] msize_q;

  // Request registers.
  logic              cmd_q;
  logic [AW-1:0]     addr_q;
  logic [DATA_W-1:0] wdata_q;
  logic              oob_q;
  lookup_t           look_q;
  logic [SW-1:0]     slot_q;
  logic [AW-1:0]     victim_tag_q;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] rdata_q;
  logic              hit_q;
  logic              status_q;

  logic              in_fire;
  logic              exec_fire;
  logic              mem_busy;
  logic [EXTW-1:0]   msize_eff;
  logic              oob;
  lookup_t           look;
  logic [SW-1:0]     hit_slot;
  logic [SW-1:0]     victim_slot;
  logic [SW-1:0]     alloc_slot;
  logic [SW-1:0]     slot_d;
  logic [AW-1:0]     victim_tag;
  logic [DATA_W-1:0] dat_rd;
  logic [DATA_W-1:0] mem_rd;
  logic [DATA_W-1:0] value;
  upd_kind_e         upd;
  logic              dat_we;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  // Configuration registers; writes beyond the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      msize_q <= MSIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CAPACITY: cap_q   <= cfg_data_i[CAP_W-1:0];
        CFG_MEM_SIZE: msize_q <= cfg_data_i[MSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Bound check against the memory size clamped to the memory depth.
  always_comb begin
    if (EXTW'(msize_q) > EXTW'(MEM_WORDS)) begin
      msize_eff = EXTW'(MEM_WORDS);
    end else begin
      msize_eff = EXTW'(msize_q);
    end
  end

  assign oob = EXTW'(address_i) >= msize_eff;

  // Handshakes and sequencing.
  assign in_ready_o = (state_q == ST_IDLE) && !mem_busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign exec_fire  = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire)   state_d = ST_EXEC;
      ST_EXEC: if (exec_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // The slot used later: the hit, a free slot, or the least recent entry.
  always_comb begin
    if (look.hit) begin
      slot_d = hit_slot;
    end else if (look.room) begin
      slot_d = alloc_slot;
    end else begin
      slot_d = victim_slot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q        <= command_i;
      addr_q       <= address_i[AW-1:0];
      wdata_q      <= write_data_i;
      oob_q        <= oob;
      look_q       <= look;
      slot_q       <= slot_d;
      victim_tag_q <= victim_tag;
    end
  end

  // Completion: pick the word and the write-back, and update the entry state.
  always_comb begin
    if (cmd_q == CMD_WRITE) begin
      value = wdata_q;
    end else if (look_q.hit) begin
      value = dat_rd;
    end else begin
      value = mem_rd;
    end
    upd       = UPD_NONE;
    dat_we    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = value;
    if (exec_fire && !oob_q) begin
      if (look_q.hit) begin
        upd    = UPD_HIT;
        dat_we = cmd_q == CMD_WRITE;
      end else if (look_q.room) begin
        upd    = UPD_ALLOC;
        dat_we = 1'b1;
      end else if (look_q.empty) begin
        // No cache entries at all: the write goes straight to memory.
        mem_we = cmd_q == CMD_WRITE;
      end else begin
        // Replace the least recent entry after writing it back.
        upd       = UPD_EVICT;
        dat_we    = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = victim_tag_q;
        mem_wdata = dat_rd;
      end
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      rdata_q  <= (oob_q || cmd_q == CMD_WRITE) ? '0 : value;
      hit_q    <= look_q.hit && !oob_q;
      status_q <= oob_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign hit_o       = hit_q;
  assign status_o    = status_q;

  lruwb_tag_array #(
    .NUM_ENTRIES (CACHE_ENTRIES),
    .AW          (AW)
  ) u_tags (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cap_i         (cap_q),
    .lookup_addr_i (address_i[AW-1:0]),
    .lookup_o      (look),
    .hit_slot_o    (hit_slot),
    .victim_slot_o (victim_slot),
    .alloc_slot_o  (alloc_slot),
    .victim_tag_o  (victim_tag),
    .upd_i         (upd),
    .upd_slot_i    (slot_q),
    .upd_tag_i     (addr_q)
  );

  lruwb_data_mem #(
    .DEPTH (CACHE_ENTRIES)
  ) u_data (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (slot_d),
    .rd_data_o (dat_rd),
    .wr_en_i   (dat_we),
    .wr_addr_i (slot_q),
    .wr_data_i (value)
  );

  lruwb_backing_mem #(
    .WORDS (MEM_WORDS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (mem_busy),
    .rd_en_i   (in_fire && !oob),
    .rd_addr_i (address_i[AW-1:0]),
    .rd_data_o (mem_rd),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata)
  );

endmodule

// File: bench/lru_write_back_cache_unit_tb.sv
// Self-checking testbench for the LRU write-back cache unit with a cycle-free shadow cache.
`timescale 1ns / 1ps

module lru_write_back_cache_unit_tb;
  import lruwb_pkg::*;

  localparam int NUM_ENTRIES  = DEF_CACHE_ENTRIES;
  localparam int NUM_WORDS    = DEF_MEM_WORDS;
  localparam int WORD_AW      = $clog2(NUM_WORDS);
  localparam int STALL_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam longint RUN_LIMIT_NS = 64'd20 * 64'd400000;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              status;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic                     command_i    = CMD_READ;
  logic [ADDR_W-1:0]        address_i    = '0;
  logic signed [DATA_W-1:0] write_data_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic signed [DATA_W-1:0] read_data_o;
  logic                     hit_o;
  logic                     status_o;
  logic                     cfg_valid_i  = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i  = CFG_CAPACITY;
  logic [CFG_DATA_W-1:0]    cfg_data_i   = '0;

  // Shadow copy of the cache, its ranks and the backing memory.
  logic [ADDR_W-1:0] shadow_tag  [NUM_ENTRIES];
  logic [DATA_W-1:0] shadow_data [NUM_ENTRIES];
  int unsigned       shadow_rank [NUM_ENTRIES];
  int unsigned       shadow_fill;
  logic [DATA_W-1:0] shadow_mem  [NUM_WORDS];
  int unsigned       cap_setting;
  int unsigned       msize_setting;

  request_t    request_queue[$];
  result_t     awaited_results[$];
  request_t    offer;
  int unsigned issued_count    = 0;
  int unsigned completed_count = 0;
  int unsigned mismatch_count  = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  logic        stall_armed     = 1'b0;
  logic        stall_done      = 1'b0;
  int unsigned stall_left      = STALL_CYCLES;

  always #10 clk_i = ~clk_i;

  lru_write_back_cache_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .hit_o        (hit_o),
    .status_o     (status_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Make every valid entry whose rank is below the limit one step older.
  function automatic void age_entries(int unsigned limit);
    for (int unsigned i = 0; i < shadow_fill && i < NUM_ENTRIES; i++) begin
      if (shadow_rank[i] < limit) shadow_rank[i]++;
    end
  endfunction

  // Apply one access to the shadow cache and return the result it must produce.
  function automatic result_t cache_access(request_t req);
    int unsigned       cap;
    int unsigned       msize;
    int unsigned       slot;
    int unsigned       last;
    logic              found;
    logic [DATA_W-1:0] value;
    result_t           res;
    cap   = (cap_setting > NUM_ENTRIES) ? NUM_ENTRIES : cap_setting;
    msize = (msize_setting > NUM_WORDS) ? NUM_WORDS : msize_setting;
    res   = '0;
    if (req.addr >= msize) begin
      res.status = 1'b1;
      return res;
    end
    found = 1'b0;
    slot  = 0;
    for (int unsigned i = 0; i < shadow_fill && i < NUM_ENTRIES; i++) begin
      if (!found && shadow_tag[i] == req.addr) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      age_entries(shadow_rank[slot]);
      shadow_rank[slot] = 0;
      if (req.cmd == CMD_WRITE) shadow_data[slot] = req.wdata;
      value   = shadow_data[slot];
      res.hit = 1'b1;
    end else begin
      value = (req.cmd == CMD_WRITE) ? req.wdata : shadow_mem[req.addr[WORD_AW-1:0]];
      if (shadow_fill < cap) begin
        // Room left: allocate the next free slot.
        slot = shadow_fill;
        age_entries(32'hFFFF_FFFF);
        shadow_fill++;
        shadow_tag[slot]  = req.addr;
        shadow_data[slot] = value;
        shadow_rank[slot] = 0;
      end else if (shadow_fill == 0) begin
        // No entry at all: the access goes straight to memory.
        shadow_mem[req.addr[WORD_AW-1:0]] = value;
      end else begin
        // Write back the least recent entry and reuse its slot.
        last = shadow_fill - 1;
        for (int unsigned i = 0; i < shadow_fill && i < NUM_ENTRIES; i++) begin
          if (!found && shadow_rank[i] == last) begin
            slot  = i;
            found = 1'b1;
          end
        end
        shadow_mem[shadow_tag[slot][WORD_AW-1:0]] = shadow_data[slot];
        age_entries(last);
        shadow_tag[slot]  = req.addr;
        shadow_data[slot] = value;
        shadow_rank[slot] = 0;
      end
    end
    if (req.cmd == CMD_READ) res.read_data = value;
    return res;
  endfunction

  // Write one register while the block is idle and mirror it in the shadow copy.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_CAPACITY) begin
      cap_setting = value & 32'hF;
    end else begin
      msize_setting = value & 32'h7FF;
    end
  endtask

  task automatic push_request(logic cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
    request_queue.push_back('{cmd: cmd, addr: addr, wdata: wdata});
    issued_count++;
  endtask

  // Block until every queued request has produced its result.
  task automatic wait_idle();
    while (completed_count != issued_count) @(posedge clk_i);
  endtask

  // Random accesses, mostly to a small hot set of in-range addresses.
  task automatic random_burst(int unsigned count);
    int unsigned       span;
    int unsigned       roll;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    span = (msize_setting > NUM_WORDS) ? NUM_WORDS : msize_setting;
    repeat (count) begin
      roll = $urandom_range(99);
      if (span == 0 || roll >= 94) begin
        addr = ADDR_W'($urandom);
      end else if (roll < 55) begin
        addr = ADDR_W'($urandom_range(((span < 12) ? span : 12) - 1));
      end else if (roll < 85) begin
        addr = ADDR_W'($urandom_range(span - 1));
      end else begin
        addr = ADDR_W'(span + $urandom_range(65535 - span));
      end
      roll = $urandom_range(99);
      if (roll < 5) begin
        wdata = 32'h8000_0000;
      end else if (roll < 10) begin
        wdata = 32'h7FFF_FFFF;
      end else begin
        wdata = $urandom;
      end
      push_request($urandom_range(1) ? CMD_WRITE : CMD_READ, addr, wdata);
    end
  endtask

  // Request driver: predicts each accepted request, then offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) awaited_results.push_back(cache_access(offer));
      if (!in_valid_i || in_ready_o) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offer = request_queue.pop_front();
          in_valid_i   <= 1'b1;
          command_i    <= offer.cmd;
          address_i    <= offer.addr;
          write_data_i <= offer.wdata;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: read_data %0d hit %0b status %0b",
                   read_data_o, hit_o, status_o);
        end
      end else begin
        want = awaited_results.pop_front();
        completed_count++;
        if (read_data_o !== want.read_data || hit_o !== want.hit ||
            status_o !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result %0d: expected read_data %0d hit %0b status %0b, got %0d %0b %0b",
                     completed_count, $signed(want.read_data), want.hit, want.status,
                     read_data_o, hit_o, status_o);
          end
        end
      end
    end
    out_ready_i <= !(stall_armed && !stall_done) && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off so the block fills up and backs up the request side.
  always @(posedge clk_i) begin
    if (stall_armed && !stall_done) begin
      if (stall_left == 0) begin
        stall_done <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  // Stimulus sequence and final verdict.
  initial begin
    for (int i = 0; i < NUM_WORDS; i++) shadow_mem[i] = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_tag[i]  = '0;
      shadow_data[i] = '0;
      shadow_rank[i] = 0;
    end
    shadow_fill   = 0;
    cap_setting   = 32'(CAP_RESET);
    msize_setting = 32'(MSIZE_RESET);
    send_idle_pct = 13;
    recv_idle_pct = 71;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Capacity zero with an empty cache passes accesses straight to memory.
    write_reg(CFG_CAPACITY, 0);
    push_request(CMD_WRITE, 16'd5, 32'h1234_5678);
    push_request(CMD_READ, 16'd5, 32'h0);
    push_request(CMD_READ, 16'd6, 32'hFFFF_FFFF);
    wait_idle();

    // Field extremes, write hits, out-of-bound addresses, then fill and evict.
    write_reg(CFG_CAPACITY, 8);
    push_request(CMD_READ, 16'd0, 32'h0);
    push_request(CMD_WRITE, 16'd1023, 32'h7FFF_FFFF);
    push_request(CMD_READ, 16'd1023, 32'h0);
    push_request(CMD_WRITE, 16'd0, 32'h8000_0000);
    push_request(CMD_READ, 16'd1024, 32'h0);
    push_request(CMD_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    push_request(CMD_READ, 16'd0, 32'h0);
    for (int a = 2; a <= 8; a++) push_request(CMD_WRITE, ADDR_W'(a), 32'h0101_0101 * a);
    push_request(CMD_READ, 16'd1023, 32'h0);
    wait_idle();

    // Capacity lowered below the current occupancy.
    write_reg(CFG_CAPACITY, 2);
    push_request(CMD_READ, 16'd0, 32'h0);
    push_request(CMD_READ, 16'd100, 32'h0);
    wait_idle();

    // Memory size zero puts every address out of bound.
    write_reg(CFG_CAPACITY, 0);
    write_reg(CFG_MEM_SIZE, 0);
    push_request(CMD_READ, 16'd5, 32'h0);
    wait_idle();

    // Oversized registers saturate at the built-in sizes.
    write_reg(CFG_CAPACITY, 15);
    write_reg(CFG_MEM_SIZE, 2047);
    push_request(CMD_READ, 16'd1023, 32'h0);
    push_request(CMD_WRITE, 16'd1024, 32'h5A5A_A5A5);
    wait_idle();

    // Random traffic under three idling patterns and several register settings.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 71;
        end
        1: begin
          send_idle_pct = 71;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int part = 0; part < 3; part++) begin
        case (part)
          0: begin
            write_reg(CFG_CAPACITY, $urandom_range(8, 1));
            write_reg(CFG_MEM_SIZE, 1024);
          end
          1: begin
            write_reg(CFG_CAPACITY, $urandom_range(15));
            write_reg(CFG_MEM_SIZE, $urandom_range(2047, 1));
          end
          default: begin
            write_reg(CFG_CAPACITY, 8);
            write_reg(CFG_MEM_SIZE, $urandom_range(64, 16));
          end
        endcase
        random_burst(222);
        if (phase == 2 && part == 0) stall_armed = 1'b1;
        wait_idle();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("lru_write_back_cache_unit test passed");
    end else begin
      $display("lru_write_back_cache_unit test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT_NS);
    $display("lru_write_back_cache_unit test failed");
    $finish;
  end

endmodule
